[hw/rtl/point_alarm_limit_tracker_macros.svh]
// Assertion macros shared by the checker.
`ifndef POINT_ALARM_LIMIT_TRACKER_MACROS_SVH
`define POINT_ALARM_LIMIT_TRACKER_MACROS_SVH

// Same-cycle implication.
`define PALTR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PALTR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/paltr_pkg.sv]
package paltr_pkg;

  localparam int unsigned PointW     = 10;
  localparam int unsigned RuleW      = 3;
  localparam int unsigned RuleCount  = 7;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned LimitEnW   = 5;
  localparam int unsigned PointTypeW = 2;
  localparam int unsigned MaxDepth   = 1 << PointW;
  localparam int unsigned DefPointCount = 1024;

  localparam logic [RuleW-1:0] RULE_DATA_QUALITY = 3'd0;
  localparam logic [RuleW-1:0] RULE_HIGH_HIGH    = 3'd1;
  localparam logic [RuleW-1:0] RULE_HIGH         = 3'd2;
  localparam logic [RuleW-1:0] RULE_LOW_LOW      = 3'd3;
  localparam logic [RuleW-1:0] RULE_LOW          = 3'd4;
  localparam logic [RuleW-1:0] RULE_STATE        = 3'd5;
  localparam logic [RuleW-1:0] RULE_STALE        = 3'd6;

  // Critical rules: quality, high-high, low-low.
  localparam logic [RuleCount-1:0] RULE_CRITICAL = 7'b0001011;

  localparam logic                  KIND_STALE  = 1'b1;
  localparam logic [PointTypeW-1:0] PT_ANALOG   = 2'd0;
  localparam logic [PointTypeW-1:0] PT_COUNTER  = 2'd1;
  localparam logic [PointTypeW-1:0] PT_DIGITAL  = 2'd2;

  localparam int unsigned EN_HIGH_HIGH = 0;
  localparam int unsigned EN_HIGH      = 1;
  localparam int unsigned EN_LOW_LOW   = 2;
  localparam int unsigned EN_LOW       = 3;
  localparam int unsigned EN_STATE     = 4;

  typedef logic [RuleCount-1:0] flags_t;

  typedef struct packed {
    logic                        kind;
    logic [PointW-1:0]           point_index;
    logic [PointTypeW-1:0]       point_type;
    logic signed [ValueBits-1:0] sample_value;
    logic                        quality_bad;
    logic                        digital_state;
    logic [LimitEnW-1:0]         limit_enable;
    logic signed [ValueBits-1:0] high_high_limit;
    logic signed [ValueBits-1:0] high_limit;
    logic signed [ValueBits-1:0] low_low_limit;
    logic signed [ValueBits-1:0] low_limit;
    logic                        expected_state;
  } in_item_t;

  typedef struct packed {
    logic [PointW-1:0]           event_point;
    logic [RuleW-1:0]            event_rule;
    logic                        event_severity;
    logic                        event_active;
    logic signed [ValueBits-1:0] event_value;
    logic                        event_last;
  } out_item_t;

  typedef struct packed {
    flags_t evaluated;
    flags_t active;
  } rule_eval_t;

endpackage

[hw/rtl/paltr_flag_ram.sv]
module paltr_flag_ram #(
  parameter int unsigned Depth = paltr_pkg::MaxDepth,
  parameter int unsigned AddrW = 10
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  paltr_pkg::flags_t     wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output paltr_pkg::flags_t     rdata_o
);
  import paltr_pkg::*;

  flags_t mem_q [Depth];
  flags_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/paltr_rule_eval.sv]
module paltr_rule_eval (
  input  paltr_pkg::in_item_t   item_i,
  output paltr_pkg::rule_eval_t eval_o
);
  import paltr_pkg::*;

  logic hh, h, ll, l, is_limit;
  flags_t evaluated, active;

  always_comb begin
    hh = item_i.limit_enable[EN_HIGH_HIGH] &&
         (item_i.sample_value >= item_i.high_high_limit);
    h  = item_i.limit_enable[EN_HIGH] &&
         (item_i.sample_value >= item_i.high_limit) && !hh;
    ll = item_i.limit_enable[EN_LOW_LOW] &&
         (item_i.sample_value <= item_i.low_low_limit);
    l  = item_i.limit_enable[EN_LOW] &&
         (item_i.sample_value <= item_i.low_limit) && !ll;
    is_limit = (item_i.point_type == PT_ANALOG) || (item_i.point_type == PT_COUNTER);

    evaluated = '0;
    active    = '0;
    if (item_i.kind == KIND_STALE) begin
      evaluated[RULE_STALE] = 1'b1;
      active[RULE_STALE]    = 1'b1;
    end else begin
      evaluated[RULE_DATA_QUALITY] = 1'b1;
      active[RULE_DATA_QUALITY]    = item_i.quality_bad;
      evaluated[RULE_HIGH_HIGH]    = is_limit;
      evaluated[RULE_HIGH]         = is_limit;
      evaluated[RULE_LOW_LOW]      = is_limit;
      evaluated[RULE_LOW]          = is_limit;
      active[RULE_HIGH_HIGH]       = hh;
      active[RULE_HIGH]            = h;
      active[RULE_LOW_LOW]         = ll;
      active[RULE_LOW]             = l;
      evaluated[RULE_STATE] = (item_i.point_type == PT_DIGITAL) &&
                              item_i.limit_enable[EN_STATE];
      active[RULE_STATE]    = item_i.digital_state != item_i.expected_state;
      evaluated[RULE_STALE] = 1'b1;
    end
  end

  assign eval_o = '{evaluated: evaluated, active: active};

endmodule

[hw/rtl/point_alarm_limit_tracker.sv]
// Point alarm tracker: each item passes through accept, flag memory read,
// compare and write back, then one emit step per alarm transition it
// causes, paced by the read-modify-write of the flag memory and the output
// register, which takes one result per cycle while the output is not stalled.
// The next item is accepted while the final transition still waits in the output register.
// After reset a clearing pass writes every one of the min(POINT_COUNT, 1024)
// flag entries, during which no item is accepted. Items naming a point at or
// above POINT_COUNT are dropped without results.
module point_alarm_limit_tracker #(
  parameter int unsigned POINT_COUNT = paltr_pkg::DefPointCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  paltr_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output paltr_pkg::out_item_t out_item_o
);
  import paltr_pkg::*;

  localparam int unsigned MemDepth = (POINT_COUNT > MaxDepth) ? MaxDepth : POINT_COUNT;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EMIT
  } state_e;

  state_e     state_q;
  in_item_t   item_q;
  rule_eval_t eval_q;
  flags_t     pend_q;
  logic [AddrW-1:0] clr_addr_q;
  logic       out_valid_q;
  out_item_t  out_item_q;

  rule_eval_t eval_w;
  flags_t     rd_flags, new_flags, change;
  logic       ram_we;
  logic [AddrW-1:0] ram_waddr;
  flags_t     ram_wdata;
  logic       in_fire, in_range, out_free, emit_fire;
  logic [RuleW-1:0] sel_rule;
  flags_t     pend_rest;

  paltr_rule_eval u_eval (
    .item_i(item_q),
    .eval_o(eval_w)
  );

  paltr_flag_ram #(
    .Depth(MemDepth),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(item_q.point_index[AddrW-1:0]),
    .rdata_o(rd_flags)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = 32'(in_item_i.point_index) < POINT_COUNT;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_fire  = (state_q == ST_EMIT) && out_free;

  assign change    = eval_q.evaluated & (eval_q.active ^ rd_flags);
  assign new_flags = (rd_flags & ~eval_q.evaluated) | (eval_q.active & eval_q.evaluated);

  assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_EVAL);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : item_q.point_index[AddrW-1:0];
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : new_flags;

  always_comb begin
    sel_rule = RULE_DATA_QUALITY;
    for (int i = RuleCount - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_rule = RuleW'(i);
      end
    end
    pend_rest = pend_q;
    pend_rest[sel_rule] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      item_q      <= '0;
      eval_q      <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + AddrW'(1);
          if (clr_addr_q == AddrW'(MemDepth - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            item_q <= in_item_i;
            if (in_range) begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          eval_q  <= eval_w;
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          pend_q  <= change;
          state_q <= (change == '0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_item_q.event_point    <= item_q.point_index;
            out_item_q.event_rule     <= sel_rule;
            out_item_q.event_severity <= RULE_CRITICAL[sel_rule];
            out_item_q.event_active   <= eval_q.active[sel_rule];
            out_item_q.event_value    <= (sel_rule == RULE_STALE) ? '0 : item_q.sample_value;
            out_item_q.event_last     <= (pend_rest == '0);
            pend_q                    <= pend_rest;
            if (pend_rest == '0) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hw/rtl/paltr_checker.sv]
`include "point_alarm_limit_tracker_macros.svh"

module paltr_checker #(
  parameter int unsigned POINT_COUNT = paltr_pkg::DefPointCount
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input paltr_pkg::in_item_t  in_item_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input paltr_pkg::out_item_t out_item_o
);
  import paltr_pkg::*;

  `PALTR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "stalled item changed")
  `PALTR_ASSERT_IMP(a_stale_zero, clk_i, rst_ni, out_valid_o && (out_item_o.event_rule == RULE_STALE), out_item_o.event_value == '0, "stale item carries a value")
  `PALTR_ASSERT_IMP(a_severity, clk_i, rst_ni, out_valid_o, out_item_o.event_severity == ((out_item_o.event_rule == RULE_DATA_QUALITY) || (out_item_o.event_rule == RULE_HIGH_HIGH) || (out_item_o.event_rule == RULE_LOW_LOW)), "severity does not match rule")
  `PALTR_ASSERT_NXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (32'(in_item_i.point_index) < POINT_COUNT), !in_ready_o, "ready held during update")

endmodule

bind point_alarm_limit_tracker paltr_checker #(
  .POINT_COUNT(POINT_COUNT)
) u_paltr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
